/* src/bta_pkg.sv */
// shared constants, types and helpers for the buddy tree allocator
// no dependencies; imported by every module of the block
package bta_pkg;

    localparam int TREE_LEVELS = 8;
    localparam int POOL_WORDS  = 128;
    localparam int NODE_COUNT  = 2 * POOL_WORDS - 1;
    localparam int POOL_BYTES  = 8 * POOL_WORDS;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int LVL_W       = $clog2(TREE_LEVELS);
    localparam int USED_W      = 11;
    localparam int REQ_W       = 11;
    localparam int WORD_W      = 8;
    localparam int BADDR_W     = 7;
    localparam int BYTES_W     = 11;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_BAD_ADDR  = 2'd2,
        ST_NOT_TAKEN = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // one tree node as held in the node memory
    typedef struct packed {
        logic              taken;
        logic [USED_W-1:0] used;
    } node_word_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic root_step;
        logic desc_step;
        logic up_step;
        logic push;
    } dp_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic in_free;
        logic early_done;
        logic root_fail;
        logic root_found;
        logic desc_fail;
        logic desc_found;
        logic up_last;
        logic out_free;
    } dp_sts_t;

    // tree level whose block size is the request rounded up to a power of two, at least 8
    function automatic logic [LVL_W-1:0] size_level(input logic [REQ_W-1:0] bytes);
        logic [LVL_W-1:0] lvl;
        int l;
        lvl = '0;
        for (l = 0; l < TREE_LEVELS; l++)
        begin
            if (int'(bytes) <= (POOL_BYTES >> l))
            begin
                lvl = LVL_W'(l);
            end
        end
        return lvl;
    endfunction

endpackage

/* src/bta_datapath.sv */
// datapath of the buddy tree allocator: node memory, walk registers, result and output registers
// depends on bta_pkg
module bta_datapath
    import bta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_ctl_t             ctl,
    output dp_sts_t             sts,
    input  logic                in_cmd,
    input  logic [REQ_W-1:0]    in_bytes,
    input  logic [WORD_W-1:0]   in_word,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [1:0]          out_status,
    output logic [BADDR_W-1:0]  out_addr,
    output logic [BYTES_W-1:0]  out_bytes
);

    localparam logic [USED_W:0]  CAP_ROOT = (USED_W + 1)'(POOL_BYTES);
    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(POOL_WORDS - 1);
    localparam logic [BADDR_W-1:0] HALF_WORDS = BADDR_W'(POOL_WORDS / 2);

    // node memory and its valid bits
    node_word_t             node_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0]  valid_reg;
    node_word_t             mem_a_reg, mem_b_reg;
    logic                   va_reg, vb_reg;

    logic                   rd_en_a, rd_en_b, wr_en;
    logic [NODE_W-1:0]      rd_addr_a, rd_addr_b, wr_addr;
    node_word_t             wr_word;

    // walk registers
    logic                   is_free_reg;
    logic [BYTES_W-1:0]     sz_reg;
    logic [LVL_W-1:0]       tgt_reg;
    logic [LVL_W-1:0]       dp_reg;
    logic [NODE_W-1:0]      node_reg;
    logic [BADDR_W-1:0]     addr_reg;
    logic                   hit_reg;
    logic                   first_reg;

    status_t                res_status_reg;
    logic [BADDR_W-1:0]     res_addr_reg;
    logic [BYTES_W-1:0]     res_bytes_reg;

    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [BADDR_W-1:0]     out_addr_reg;
    logic [BYTES_W-1:0]     out_bytes_reg;

    node_word_t             word_a, word_b;
    logic [LVL_W-1:0]       in_lvl;
    logic [NODE_W-1:0]      in_leaf;
    logic [USED_W:0]        root_sum;
    logic                   go_right;
    logic [USED_W-1:0]      child_used;
    logic [NODE_W-1:0]      child, left, right;
    logic [NODE_W-1:0]      child_l, child_r;
    logic [LVL_W-1:0]       child_lvl;
    logic [USED_W:0]        desc_sum, desc_cap;
    logic                   hit_now, adj;
    logic [NODE_W-1:0]      parent;
    logic [USED_W-1:0]      used_add, used_sub;

    assign word_a = va_reg ? mem_a_reg : '0;
    assign word_b = vb_reg ? mem_b_reg : '0;

    assign in_lvl  = size_level(in_bytes);
    assign in_leaf = NODE_W'(in_word) + LEAF_BASE;

    // root check
    assign root_sum = {1'b0, word_a.used} + {1'b0, sz_reg};

    // descent: port a holds the left child, port b the right
    assign left       = NODE_W'({node_reg, 1'b1});
    assign right      = left + NODE_W'(1);
    assign go_right   = word_a.used > word_b.used;
    assign child      = go_right ? right : left;
    assign child_used = go_right ? word_b.used : word_a.used;
    assign child_lvl  = dp_reg + LVL_W'(1);
    assign desc_sum   = {1'b0, child_used} + {1'b0, sz_reg};
    assign desc_cap   = CAP_ROOT >> child_lvl;
    assign child_l    = NODE_W'({child, 1'b1});
    assign child_r    = child_l + NODE_W'(1);

    // upward walk
    assign hit_now  = !hit_reg && word_a.taken;
    assign adj      = hit_reg || hit_now;
    assign parent   = (node_reg - NODE_W'(1)) >> 1;
    assign used_add = word_a.used + sz_reg;
    assign used_sub = (word_a.used >= sz_reg) ? (word_a.used - sz_reg) : '0;

    always_comb
    begin
        sts.in_free    = (in_cmd == CMD_FREE);
        sts.early_done = (in_cmd == CMD_FREE) ? (int'(in_word) >= POOL_WORDS)
                                              : (int'(in_bytes) > POOL_BYTES);
        sts.root_fail  = root_sum > CAP_ROOT;
        sts.root_found = (tgt_reg == '0);
        sts.desc_fail  = desc_sum > desc_cap;
        sts.desc_found = (child_lvl == tgt_reg);
        sts.up_last    = (node_reg == '0);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    // memory port selection
    always_comb
    begin
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_en     = 1'b0;
        wr_addr   = node_reg;
        wr_word   = word_a;
        if (ctl.load)
        begin
            rd_en_a   = 1'b1;
            rd_addr_a = (in_cmd == CMD_FREE) ? in_leaf : '0;
        end
        else if (ctl.root_step)
        begin
            if (sts.root_found)
            begin
                rd_en_a   = 1'b1;
                rd_addr_a = '0;
            end
            else
            begin
                rd_en_a   = 1'b1;
                rd_en_b   = 1'b1;
                rd_addr_a = NODE_W'(1);
                rd_addr_b = NODE_W'(2);
            end
        end
        else if (ctl.desc_step)
        begin
            if (sts.desc_found)
            begin
                rd_en_a   = 1'b1;
                rd_addr_a = child;
            end
            else
            begin
                rd_en_a   = 1'b1;
                rd_en_b   = 1'b1;
                rd_addr_a = child_l;
                rd_addr_b = child_r;
            end
        end
        else if (ctl.up_step)
        begin
            wr_en = adj;
            if (!is_free_reg)
            begin
                wr_word.used  = used_add;
                wr_word.taken = first_reg ? 1'b1 : word_a.taken;
            end
            else
            begin
                wr_word.used  = used_sub;
                wr_word.taken = hit_now ? 1'b0 : word_a.taken;
            end
            if (!sts.up_last)
            begin
                rd_en_a   = 1'b1;
                rd_addr_a = parent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_word;
        end
        if (rd_en_a)
        begin
            mem_a_reg <= node_mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            mem_b_reg <= node_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en_a)
            begin
                va_reg <= valid_reg[rd_addr_a];
            end
            if (rd_en_b)
            begin
                vb_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    // walk and result registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            is_free_reg    <= (in_cmd == CMD_FREE);
            sz_reg         <= (in_cmd == CMD_FREE) ? BYTES_W'(8)
                                                   : (BYTES_W'(POOL_BYTES) >> in_lvl);
            tgt_reg        <= in_lvl;
            dp_reg         <= '0;
            node_reg       <= (in_cmd == CMD_FREE) ? in_leaf : '0;
            addr_reg       <= '0;
            hit_reg        <= (in_cmd == CMD_ALLOC);
            first_reg      <= 1'b1;
            res_status_reg <= (in_cmd == CMD_FREE) ? ST_BAD_ADDR : ST_NO_ROOM;
            res_addr_reg   <= '0;
            res_bytes_reg  <= '0;
        end
        else if (ctl.root_step)
        begin
            res_status_reg <= ST_NO_ROOM;
        end
        else if (ctl.desc_step)
        begin
            if (!sts.desc_fail)
            begin
                node_reg <= child;
                dp_reg   <= child_lvl;
                addr_reg <= addr_reg + (go_right ? (HALF_WORDS >> dp_reg) : '0);
            end
        end
        else if (ctl.up_step)
        begin
            first_reg <= 1'b0;
            if (hit_now)
            begin
                hit_reg <= 1'b1;
            end
            if (!adj)
            begin
                sz_reg <= sz_reg << 1;
            end
            if (!sts.up_last)
            begin
                node_reg <= parent;
            end
            else
            begin
                res_status_reg <= adj ? ST_OK : ST_NOT_TAKEN;
                res_addr_reg   <= is_free_reg ? '0 : addr_reg;
                res_bytes_reg  <= adj ? sz_reg : '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_bytes_reg  <= res_bytes_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;
    assign out_bytes  = out_bytes_reg;

endmodule

/* src/bta_ctrl.sv */
// sequencing state machine of the buddy tree allocator
// depends on bta_pkg
module bta_ctrl
    import bta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_ctl_t ctl
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROOT = 5'b00010,
        S_DESC = 5'b00100,
        S_UP   = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load = 1'b1;
                    priority if (sts.early_done)
                        state_next = S_DONE;
                    else if (sts.in_free)
                        state_next = S_UP;
                    else
                        state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                ctl.root_step = 1'b1;
                priority if (sts.root_fail)
                    state_next = S_DONE;
                else if (sts.root_found)
                    state_next = S_UP;
                else
                    state_next = S_DESC;
            end
            S_DESC:
            begin
                ctl.desc_step = 1'b1;
                priority if (sts.desc_fail)
                    state_next = S_DONE;
                else if (sts.desc_found)
                    state_next = S_UP;
                else
                    state_next = S_DESC;
            end
            S_UP:
            begin
                ctl.up_step = 1'b1;
                if (sts.up_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    ctl.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/buddy_tree_allocator.sv */
// top level of the buddy tree allocator: stream ports, controller and datapath
// depends on bta_pkg, bta_ctrl, bta_datapath
//
// channel   dir   tdata                                      tuser
// s_*       in    req_bytes[10:0] word_addr[18:11]           cmd (0 alloc, 1 free)
// m_*       out   status[1:0] block_addr[8:2] bytes[19:9]    -
//
// one request at a time; a beat is taken only while the controller is idle
// allocate: accept, root check, descent level by level, update of each node on the way
//   back up, hand-off; an oversize request or one with no room skips to the hand-off
// free: accept, climb from leaf to root, hand-off; an address past the pool skips the climb
// the descent is bound by the registered read of the node memory, the climb by its write port
// reset empties the pool at once through a valid bit per tree node
// a result waits in the output register while the next request is taken
module buddy_tree_allocator
    import bta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_bytes[10:0], word_addr[18:11], zero pad
    input  logic [0:0]  s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], block_addr[8:2], block_bytes[19:9], zero pad
);

    dp_ctl_t               ctl;
    dp_sts_t               sts;
    logic [1:0]            out_status;
    logic [BADDR_W-1:0]    out_addr;
    logic [BYTES_W-1:0]    out_bytes;

    // state machine: walks root check, descent and upward update
    bta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // node memory, walk registers, output register
    bta_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (s_tuser[0]),
        .in_bytes   (s_tdata[REQ_W-1:0]),
        .in_word    (s_tdata[REQ_W+WORD_W-1:REQ_W]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_addr   (out_addr),
        .out_bytes  (out_bytes)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {4'b0000, out_bytes, out_addr, out_status};

endmodule

/* src/bta_checker.sv */
// port-level checks for the buddy tree allocator, bound to the top level
// depends on bta_pkg
module bta_checker
    import bta_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [1:0]  chk_status;
    logic [6:0]  chk_addr;
    logic [10:0] chk_bytes;
    logic [10:0] chk_mask;
    logic        in_beat;

    assign chk_status = m_tdata[1:0];
    assign chk_addr   = m_tdata[8:2];
    assign chk_bytes  = m_tdata[19:9];
    assign chk_mask   = (chk_bytes >> 3) - 11'd1;
    assign in_beat    = s_tvalid && s_tready && (s_tdata[0] || !s_tdata[0]) && (s_tuser[0] || !s_tuser[0]);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a failure carries no block
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (chk_status != ST_OK) |-> (chk_addr == 7'd0) && (chk_bytes == 11'd0))
        else $error("failed request reports a block");

    // a good block is a power of two of at least one word
    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (chk_status == ST_OK) |-> $onehot(chk_bytes) && (chk_bytes[2:0] == 3'd0))
        else $error("block size is not a power of two word count");

    // a good block starts on a boundary of its own size
    a_ok_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (chk_status == ST_OK) |-> (({4'b0000, chk_addr} & chk_mask) == 11'd0))
        else $error("block address not aligned to its size");

    // no request is taken in the cycle right after one was taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("second request taken while one is in flight");

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb_top.sv */
// self-checking bench for buddy_tree_allocator: directed and random allocate/free traffic
// depends on bta_pkg and the buddy_tree_allocator rtl; needs no files or arguments
`timescale 1ns / 100ps

module tb_top;
    import bta_pkg::*;

    // one expected reply, the fields of m_tdata
    typedef struct {
        status_t    status;
        logic [6:0] block_addr;
        logic [10:0] block_bytes;
    } alloc_reply_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // req_bytes[10:0], word_addr[18:11], zero pad
    logic [0:0]  s_tuser = '0;   // cmd[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // status[1:0], block_addr[8:2], block_bytes[19:9], zero pad

    // shadow copy of the node tree
    int unsigned node_bytes_used [NODE_COUNT];
    bit          node_is_taken   [NODE_COUNT];

    // blocks currently held, so frees can target them
    int live_word[$];
    int live_size[$];

    alloc_reply_t pending_replies[$];

    int error_count = 0;
    int status_seen[4];
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;

    buddy_tree_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    // descend toward the less-used child until the block size matches
    function automatic alloc_reply_t predict_alloc(input int unsigned req);
        alloc_reply_t r;
        int unsigned  blk;
        int unsigned  trail[TREE_LEVELS];
        int           depth_n;
        int unsigned  node;
        int unsigned  first_word;
        int           lvl;
        bit           hit;
        r = '{ST_NO_ROOM, 7'd0, 11'd0};
        blk = 8;
        while (blk < req)
        begin
            blk = blk << 1;
        end
        if (blk > POOL_BYTES)
        begin
            return r;
        end
        depth_n = 0;
        node = 0;
        first_word = 0;
        hit = 1'b0;
        for (lvl = 0; lvl < TREE_LEVELS; lvl++)
        begin
            if (node_bytes_used[node] + blk > (POOL_BYTES >> lvl))
            begin
                break;
            end
            trail[depth_n] = node;
            depth_n++;
            if ((blk << lvl) == POOL_BYTES)
            begin
                hit = 1'b1;
                break;
            end
            if (node_bytes_used[2*node+1] <= node_bytes_used[2*node+2])
            begin
                node = 2 * node + 1;
            end
            else
            begin
                node = 2 * node + 2;
                first_word += (POOL_WORDS / 2) >> lvl;
            end
        end
        // a failed descent leaves the tree untouched
        if (!hit)
        begin
            return r;
        end
        for (int k = 0; k < depth_n; k++)
        begin
            node_bytes_used[trail[k]] += blk;
        end
        node_is_taken[node] = 1'b1;
        r = '{ST_OK, 7'(first_word), 11'(blk)};
        return r;
    endfunction

    // climb from the leaf, release the first taken node, shrink every count above
    function automatic alloc_reply_t predict_free(input int unsigned word);
        alloc_reply_t r;
        int unsigned  node;
        int unsigned  blk;
        int unsigned  height;
        bit           hit;
        if (word >= POOL_WORDS)
        begin
            r = '{ST_BAD_ADDR, 7'd0, 11'd0};
            return r;
        end
        node = word + POOL_WORDS - 1;
        height = 0;
        blk = 0;
        hit = 1'b0;
        forever
        begin
            if (!hit && node_is_taken[node])
            begin
                node_is_taken[node] = 1'b0;
                blk = 8 << height;
                hit = 1'b1;
            end
            if (hit)
            begin
                node_bytes_used[node] = (node_bytes_used[node] >= blk) ?
                                        node_bytes_used[node] - blk : 0;
            end
            if (node == 0)
            begin
                break;
            end
            node = (node - 1) >> 1;
            height++;
        end
        if (!hit)
        begin
            r = '{ST_NOT_TAKEN, 7'd0, 11'd0};
        end
        else
        begin
            r = '{ST_OK, 7'd0, 11'(blk)};
        end
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------------

    // drive one request beat, wait for the handshake, then record its reply
    // tvalid is only lowered on an idle gap, never in the step it is raised
    task automatic send_req(input cmd_t op, input int bytes, input int word);
        alloc_reply_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, 8'(word), 11'(bytes)};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (op == CMD_ALLOC)
        begin
            r = predict_alloc(bytes);
            if (r.status == ST_OK)
            begin
                live_word.push_back(r.block_addr);
                live_size.push_back(r.block_bytes);
            end
        end
        else
        begin
            r = predict_free(word);
            // drop the held block that covered this word
            if (r.status == ST_OK)
            begin
                for (int k = 0; k < live_word.size(); k++)
                begin
                    if (word >= live_word[k] && word < live_word[k] + live_size[k] / 8)
                    begin
                        live_word.delete(k);
                        live_size.delete(k);
                        break;
                    end
                end
            end
        end
        status_seen[r.status]++;
        pending_replies.push_back(r);
    endtask

    // unused field of each beat carries random bits
    task automatic do_alloc(input int bytes);
        send_req(CMD_ALLOC, bytes, $urandom_range(255));
    endtask

    task automatic do_free(input int word);
        send_req(CMD_FREE, $urandom_range(2047), word);
    endtask

    task automatic free_all_held();
        while (live_word.size() > 0)
        begin
            do_free(live_word[0]);
        end
    endtask

    // field extremes and every special case on a known tree
    task automatic test_directed();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        do_free(0);          // nothing allocated yet
        do_free(128);        // first word past the pool
        do_free(255);        // top of the address field
        do_alloc(0);         // zero size rounds to 8
        do_alloc(1);
        do_alloc(8);
        do_alloc(9);         // rounds to 16
        do_alloc(1025);      // larger than the pool
        do_alloc(2047);
        do_alloc(1024);      // pool partly used, no room
        free_all_held();
        do_alloc(1024);      // whole-pool block
        do_alloc(8);         // no room on the path
        do_free(127);        // root found from the last leaf
        do_free(127);
        do_alloc(512);
        do_alloc(512);
        do_alloc(8);
        do_free(100);
        do_free(5);
        do_free(5);
    endtask

    // mostly legal churn with random sizes, some noise frees
    task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
        int pick;
        int k;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99);
            if (live_word.size() == 0 || pick < 52)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    do_alloc($urandom_range(64));
                else if (pick < 85)
                    do_alloc($urandom_range(256, 65));
                else if (pick < 95)
                    do_alloc($urandom_range(1024, 257));
                else
                    do_alloc($urandom_range(2047, 1025));
            end
            else if (pick < 88)
            begin
                // any word inside a held block frees it
                k = $urandom_range(live_word.size() - 1);
                do_free(live_word[k] + $urandom_range(live_size[k] / 8 - 1));
            end
            else
            begin
                do_free($urandom_range(255));
            end
        end
    endtask

    // -------------------------------------------------------------------------
    // checking
    // -------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // reply side: random backpressure, compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        alloc_reply_t want;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (pending_replies.size() == 0)
                begin
                    report_mismatch("unexpected reply beat", 1, 0);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[8:2] != want.block_addr)
                        report_mismatch("block_addr", m_tdata[8:2], want.block_addr);
                    if (m_tdata[19:9] != want.block_bytes)
                        report_mismatch("block_bytes", m_tdata[19:9], want.block_bytes);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped by watchdog after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            node_bytes_used[i] = 0;
            node_is_taken[i]   = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(9, 58, 545);
        test_random(58, 9, 545);
        test_random(0, 0, 545);

        s_tvalid <= 1'b0;
        while (pending_replies.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests in %0d cycles under three backpressure mixes",
                 status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
                 cycle_count);
        $display("replies: %0d ok, %0d no room, %0d bad address, %0d not allocated",
                 status_seen[ST_OK], status_seen[ST_NO_ROOM],
                 status_seen[ST_BAD_ADDR], status_seen[ST_NOT_TAKEN]);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
